>>> hw/rtl/ica_pkg.sv
// Shared types and constants for the 64-bit constant-fold ALU.
// Used by ica_pow_step, ica_div_step and int64_constant_fold_alu; no dependencies.
`default_nettype none

package ica_pkg;

  // Datapath width; operands are truncated to this width and results sign-extended from it.
  localparam int DW       = 64;
  localparam int HALF_W   = DW / 2;
  localparam int SHW      = $clog2(DW);
  // The power chain takes two stages per exponent bit.
  localparam int PIPE_LAT = 2 * DW;
  localparam logic [DW-1:0] SHIFT_LIM = DW'(DW);

  typedef enum logic [4:0] {
    OP_POW  = 5'd0,
    OP_ADD  = 5'd1,
    OP_SUB  = 5'd2,
    OP_MUL  = 5'd3,
    OP_DIV  = 5'd4,
    OP_MOD  = 5'd5,
    OP_SHL  = 5'd6,
    OP_SHR  = 5'd7,
    OP_LT   = 5'd8,
    OP_LE   = 5'd9,
    OP_GT   = 5'd10,
    OP_GE   = 5'd11,
    OP_EQ   = 5'd12,
    OP_NE   = 5'd13,
    OP_AND  = 5'd14,
    OP_XOR  = 5'd15,
    OP_OR   = 5'd16,
    OP_LAND = 5'd17,
    OP_LOR  = 5'd18,
    OP_NOT  = 5'd19,
    OP_LNOT = 5'd20,
    OP_NEG  = 5'd21
  } op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DIV0   = 2'd1;
  localparam logic [1:0] ST_SHIFT  = 2'd2;
  localparam logic [1:0] ST_NEGPOW = 2'd3;

  // Where the final value of a transaction comes from.
  typedef enum logic [1:0] {
    SRC_SIMPLE = 2'd0,
    SRC_CHAIN  = 2'd1,
    SRC_DIV    = 2'd2,
    SRC_MOD    = 2'd3
  } src_t;

  // Square-and-multiply state.
  typedef struct packed {
    logic [DW-1:0] acc;
    logic [DW-1:0] base;
    logic [DW-1:0] ex;
  } pow_t;

  // Restoring divider state.
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] quo;
    logic [DW-1:0] dvs;
  } div_t;

  // Side information that travels with each transaction.
  typedef struct packed {
    src_t          src;
    logic [DW-1:0] val;
    logic [1:0]    st;
    logic          neg_q;
    logic          neg_r;
  } side_t;

endpackage

`default_nettype wire

>>> hw/rtl/ica_pow_step.sv
// One square-and-multiply iteration over two register stages.
// Depends on ica_pkg for widths and pow_t.
`default_nettype none

module ica_pow_step
  import ica_pkg::*;
(
  input  wire logic clk,
  input  pow_t      s_in,
  output pow_t      s_out
);

  logic [HALF_W-1:0] al, ah, bl, bh;
  logic [DW-1:0]     pa0_r, ps0_r, acc_r, ex_r;
  logic [HALF_W-1:0] pa1_r, pa2_r, ps1_r, ps2_r;
  logic              sel_r;
  pow_t              out_r;

  assign al = s_in.acc[HALF_W-1:0];
  assign ah = s_in.acc[DW-1:HALF_W];
  assign bl = s_in.base[HALF_W-1:0];
  assign bh = s_in.base[DW-1:HALF_W];

  // Stage one: half-width partial products of acc*base and base*base.
  always_ff @(posedge clk) begin
    pa0_r <= DW'(al) * DW'(bl);
    pa1_r <= HALF_W'(al * bh);
    pa2_r <= HALF_W'(ah * bl);
    ps0_r <= DW'(bl) * DW'(bl);
    ps1_r <= HALF_W'(bl * bh);
    ps2_r <= HALF_W'(bh * bl);
    acc_r <= s_in.acc;
    sel_r <= s_in.ex[0];
    ex_r  <= s_in.ex >> 1;
  end

  // Stage two: add the partial products, keep the low word.
  always_ff @(posedge clk) begin
    out_r.acc  <= sel_r ? (pa0_r + {pa1_r + pa2_r, {HALF_W{1'b0}}}) : acc_r;
    out_r.base <= ps0_r + {ps1_r + ps2_r, {HALF_W{1'b0}}};
    out_r.ex   <= ex_r;
  end

  assign s_out = out_r;

endmodule

`default_nettype wire

>>> hw/rtl/ica_div_step.sv
// One restoring division step: one quotient bit per cycle.
// Depends on ica_pkg for widths and div_t.
`default_nettype none

module ica_div_step
  import ica_pkg::*;
(
  input  wire logic clk,
  input  div_t      s_in,
  output div_t      s_out
);

  logic [DW:0] trial;
  logic        ge;
  logic [DW:0] diff;
  div_t        out_r;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {s_in.rem, s_in.quo[DW-1]};
    ge    = trial >= {1'b0, s_in.dvs};
    diff  = trial - {1'b0, s_in.dvs};
  end

  always_ff @(posedge clk) begin
    out_r.rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
    out_r.quo <= {s_in.quo[DW-2:0], ge};
    out_r.dvs <= s_in.dvs;
  end

  assign s_out = out_r;

endmodule

`default_nettype wire

>>> hw/rtl/int64_constant_fold_alu.sv
// Top level of the pipelined 64-bit constant-fold ALU.
// Depends on ica_pkg, ica_pow_step and ica_div_step.
//
// Usage:
//   A transaction enters when start is high and busy is low. busy is always
//   low, so one transaction can enter in every cycle. in_op selects the
//   operation; in_operand_a and in_operand_b are the signed operands.
//   Each transaction gives exactly one result: out_valid is high for one
//   cycle with out_value and out_status, in the order of entry.
//   Throughput is one transaction per cycle. The pipeline depth is set by
//   the power chain: one square-and-multiply step per exponent bit, each a
//   two-stage split multiplier. The restoring divider (one quotient bit
//   per stage) and the simple operations run alongside and are delayed
//   to the same depth through the side-information delay line.
//   Synchronous reset (rst_n low) drops all transactions in flight.
//   The receiver cannot stall: a result is taken in its strobe cycle.
`default_nettype none

module int64_constant_fold_alu
  import ica_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [4:0]  in_op,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  output      logic        out_valid,
  output      logic [63:0] out_value,
  output      logic [1:0]  out_status
);

  logic [DW-1:0] a, b, ma, mb;
  logic [SHW-1:0] sh;
  op_t    op;
  side_t  side_nxt;
  pow_t   pow_nxt;
  div_t   div_nxt;

  logic [PIPE_LAT:0] vld_r;
  side_t side_r [PIPE_LAT+1];
  pow_t  pow_s  [DW+1];
  div_t  div_s  [DW+1];
  side_t merged;
  logic [DW-1:0] fin_val;

  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic [1:0]  out_status_r;

  assign busy = 1'b0;
  assign a    = in_operand_a[DW-1:0];
  assign b    = in_operand_b[DW-1:0];
  assign sh   = b[SHW-1:0];
  assign op   = op_t'(in_op);
  assign ma   = a[DW-1] ? (~a + 1'b1) : a;
  assign mb   = b[DW-1] ? (~b + 1'b1) : b;

  // Entry decode: simple operations finish here, the rest pick a unit.
  always_comb begin
    side_nxt.src   = SRC_SIMPLE;
    side_nxt.val   = '0;
    side_nxt.st    = ST_OK;
    side_nxt.neg_q = a[DW-1] ^ b[DW-1];
    side_nxt.neg_r = a[DW-1];
    case (op)
      OP_POW: begin
        if (b[DW-1]) begin
          if (a == '0) begin
            side_nxt.st = ST_NEGPOW;
          end else if (a == DW'(1)) begin
            side_nxt.val = DW'(1);
          end else if (a == '1) begin
            side_nxt.val = b[0] ? '1 : DW'(1);
          end
        end else begin
          side_nxt.src = SRC_CHAIN;
        end
      end
      OP_ADD: side_nxt.val = a + b;
      OP_SUB: side_nxt.val = a - b;
      OP_MUL: side_nxt.src = SRC_CHAIN;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          side_nxt.st = ST_DIV0;
        end else begin
          side_nxt.src = (op == OP_DIV) ? SRC_DIV : SRC_MOD;
        end
      end
      OP_SHL, OP_SHR: begin
        if (b[DW-1] || (b >= SHIFT_LIM)) begin
          side_nxt.st = ST_SHIFT;
        end else if (op == OP_SHL) begin
          side_nxt.val = a << sh;
        end else begin
          side_nxt.val = $unsigned($signed(a) >>> sh);
        end
      end
      OP_LT:   side_nxt.val = DW'($signed(a) <  $signed(b));
      OP_LE:   side_nxt.val = DW'($signed(a) <= $signed(b));
      OP_GT:   side_nxt.val = DW'($signed(a) >  $signed(b));
      OP_GE:   side_nxt.val = DW'($signed(a) >= $signed(b));
      OP_EQ:   side_nxt.val = DW'(a == b);
      OP_NE:   side_nxt.val = DW'(a != b);
      OP_AND:  side_nxt.val = a & b;
      OP_XOR:  side_nxt.val = a ^ b;
      OP_OR:   side_nxt.val = a | b;
      OP_LAND: side_nxt.val = DW'((a != '0) && (b != '0));
      OP_LOR:  side_nxt.val = DW'((a != '0) || (b != '0));
      OP_NOT:  side_nxt.val = ~a;
      OP_LNOT: side_nxt.val = DW'(a == '0);
      OP_NEG:  side_nxt.val = ~a + 1'b1;
      default: side_nxt.st = ST_DIV0;
    endcase
  end

  // Chain seeds: a multiply is one step with an exponent of one.
  always_comb begin
    pow_nxt.acc  = (op == OP_MUL) ? a : DW'(1);
    pow_nxt.base = (op == OP_MUL) ? b : a;
    pow_nxt.ex   = (op == OP_MUL) ? DW'(1) : ((op == OP_POW) ? b : '0);
    div_nxt.rem  = '0;
    div_nxt.quo  = ma;
    div_nxt.dvs  = mb;
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-1:0], start & ~busy};
    end
  end

  // Entry registers.
  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    pow_s[0]  <= pow_nxt;
    div_s[0]  <= div_nxt;
  end

  // Sign fix of the divider result, applied when it leaves the divider.
  always_comb begin
    merged = side_r[DW];
    if (side_r[DW].src == SRC_DIV) begin
      merged.val = side_r[DW].neg_q ? (~div_s[DW].quo + 1'b1) : div_s[DW].quo;
      merged.src = SRC_SIMPLE;
    end else if (side_r[DW].src == SRC_MOD) begin
      merged.val = side_r[DW].neg_r ? (~div_s[DW].rem + 1'b1) : div_s[DW].rem;
      merged.src = SRC_SIMPLE;
    end
  end

  // Side-information delay line.
  for (genvar k = 0; k < PIPE_LAT; k++) begin : g_side
    if (k == DW) begin : g_merge
      always_ff @(posedge clk) begin
        side_r[k+1] <= merged;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // Power/multiply chain and divider chain.
  for (genvar i = 0; i < DW; i++) begin : g_units
    ica_pow_step u_pow (
      .clk   (clk),
      .s_in  (pow_s[i]),
      .s_out (pow_s[i+1])
    );
    ica_div_step u_div (
      .clk   (clk),
      .s_in  (div_s[i]),
      .s_out (div_s[i+1])
    );
  end

  // Output register.
  assign fin_val = (side_r[PIPE_LAT].src == SRC_CHAIN) ? pow_s[DW].acc
                                                      : side_r[PIPE_LAT].val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[PIPE_LAT];
    end
    out_value_r  <= 64'($signed(fin_val));
    out_status_r <= side_r[PIPE_LAT].st;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // A result strobe always goes back to a transaction accepted earlier.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start & ~busy, PIPE_LAT + 2))
    else $error("result without a matching transaction");

  // Every error status comes with a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_value == 64'd0))
    else $error("error status with nonzero value");

  // The block never holds off a transaction.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("busy raised");

endmodule

`default_nettype wire
